// File: src/asp_pkg.sv
// Package with shared constants, codes and control structs of the alarm slot pool.
`default_nettype none

package asp_pkg;

	// Default sizes of the slot table and the pool set.
	localparam int DEF_NUM_SLOTS = 16;
	localparam int DEF_NUM_POOLS = 4;

	// Field widths of the transfer payloads.
	localparam int POOL_W  = 2;
	localparam int DELAY_W = 32;
	localparam int ID_W    = 32;
	localparam int TIME_W  = 64;

	// Configuration register file.
	localparam int NUM_CFG    = 4;
	localparam int CFG_W      = 5;
	localparam int PADDR_W    = 4;
	localparam int APB_DATA_W = 32;
	localparam logic [NUM_CFG-1:0][CFG_W-1:0] CFG_RESET = {5'd16, 5'd16, 5'd16, 5'd0};

	// Operation codes of a request.
	typedef enum logic [1:0] {
		OP_ADD     = 2'd0,
		OP_CANCEL  = 2'd1,
		OP_ADVANCE = 2'd2,
		OP_DESTROY = 2'd3
	} op_t;

	// Status codes of a result.
	typedef enum logic [2:0] {
		ST_OK          = 3'd0,
		ST_TIME_PASSED = 3'd1,
		ST_POOL_FULL   = 3'd2,
		ST_NO_SLOT     = 3'd3,
		ST_NOT_FOUND   = 3'd4
	} status_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic ready;
		logic step;
		logic finish;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic accepted;
		logic quick;
		logic emit_hit;
		logic out_free;
		logic last_idx;
	} dp_sts_t;

endpackage

`default_nettype wire

// File: src/asp_req_if.sv
// Request channel interface of the alarm slot pool.
`default_nettype none

interface asp_req_if import asp_pkg::*; ();
	logic                valid;
	logic                ready;
	op_t                 op;
	logic [POOL_W-1:0]   pool_index;
	logic [DELAY_W-1:0]  arm_delay;
	logic                late_ok;
	logic [ID_W-1:0]     target_id;
	logic [TIME_W-1:0]   advance_us;

	modport source (output valid, op, pool_index, arm_delay, late_ok, target_id,
		advance_us, input ready);
	modport sink (input valid, op, pool_index, arm_delay, late_ok, target_id,
		advance_us, output ready);
endinterface

`default_nettype wire

// File: src/asp_rsp_if.sv
// Result channel interface of the alarm slot pool.
`default_nettype none

interface asp_rsp_if import asp_pkg::*; ();
	logic               valid;
	logic               ready;
	status_t            status;
	logic [ID_W-1:0]    timer_id;
	logic               fired;
	logic [TIME_W-1:0]  time_now;
	logic               last;

	modport source (output valid, status, timer_id, fired, time_now, last, input ready);
	modport sink (input valid, status, timer_id, fired, time_now, last, output ready);
endinterface

`default_nettype wire

// File: src/alarm_slot_pool_unit.sv
// Top level of the alarm slot pool: configuration registers, controller and datapath.
//
// Requests arrive on the req channel and results leave on the rsp channel, each a
// valid/ready transfer. Pool limits are written through the APB-style port; pready is
// always high and a write lands at the access cycle.
// Every request is handled one at a time. An add, cancel, destroy or advance offers its
// closing result after it primes the slot table read, scans each slot and closes. The
// next request is taken only when the controller is back in idle. The slot table has one
// read port and is scanned one slot per cycle unless a due alarm waits for the result
// register. An add refused for a zero delay skips the scan and goes straight to closing.
// Add, cancel and destroy give one result; advance gives one result per due alarm in slot
// order and then a closing result with last set.
// A result sits in an output register, so the next request may be taken while it waits.
// When the receiver stalls, the scan holds at a due alarm until the register frees.
// Reset clears the clock, sets the id counter to one, frees every slot and loads the
// default limits; the slot table needs no clearing pass.
`default_nettype none

module alarm_slot_pool_unit import asp_pkg::*; #(
	parameter int NUM_SLOTS = DEF_NUM_SLOTS,
	parameter int NUM_POOLS = DEF_NUM_POOLS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [PADDR_W-1:0]    paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	asp_req_if.sink               req,
	asp_rsp_if.source             rsp
);

	logic [NUM_CFG-1:0][CFG_W-1:0] limit_q;
	logic [PADDR_W-3:0]            reg_sel;
	logic                          cfg_wr;
	dp_cmd_t                       cmd;
	dp_sts_t                       sts;

	// Register decode on word addresses.
	assign pready  = 1'b1;
	assign reg_sel = paddr[PADDR_W-1:2];
	assign cfg_wr  = psel && penable && pwrite;
	assign prdata  = APB_DATA_W'(limit_q[reg_sel]);

	// Pool limit registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= CFG_RESET;
		end else if (cfg_wr) begin
			limit_q[reg_sel] <= pwdata[CFG_W-1:0];
		end
	end

	asp_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	asp_dp #(
		.NUM_SLOTS (NUM_SLOTS),
		.NUM_POOLS (NUM_POOLS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp       (rsp),
		.limit_cfg (limit_q),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule

`default_nettype wire

// File: src/asp_dp.sv
// Datapath of the alarm slot pool: clock, id counter, slot table and result register.
`default_nettype none

module asp_dp import asp_pkg::*; #(
	parameter int NUM_SLOTS = DEF_NUM_SLOTS,
	parameter int NUM_POOLS = DEF_NUM_POOLS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	asp_req_if.sink                         req,
	asp_rsp_if.source                       rsp,
	input  logic [NUM_CFG-1:0][CFG_W-1:0]   limit_cfg,
	input  dp_cmd_t                         cmd,
	output dp_sts_t                         sts
);

	localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int CW = $clog2(NUM_SLOTS + 1);
	localparam int LW = (CW > CFG_W) ? CW : CFG_W;
	localparam logic [IW-1:0] LAST_IDX = IW'(NUM_SLOTS - 1);
	localparam int NPW = (POOL_W + 1 > $clog2(NUM_POOLS + 1)) ? POOL_W + 1 :
		$clog2(NUM_POOLS + 1);
	localparam logic [NPW-1:0] NP = NPW'(NUM_POOLS);

	typedef struct packed {
		logic [POOL_W-1:0] owner;
		logic [ID_W-1:0]   id;
		logic [TIME_W-1:0] fire;
	} slot_t;

	// Slot table memory and its registered read port.
	slot_t mem [NUM_SLOTS];
	slot_t rd_s1;

	// Latched request fields.
	op_t                op_q;
	logic [POOL_W-1:0]  pool_q;
	logic [DELAY_W-1:0] delay_q;
	logic [ID_W-1:0]    target_q;
	logic               reject_q;

	// Scan and architectural state.
	logic [IW-1:0]        idx_q;
	logic [CW-1:0]        count_q;
	logic                 free_found_q;
	logic [IW-1:0]        free_idx_q;
	logic                 found_q;
	logic [NUM_SLOTS-1:0] active_q;
	logic [TIME_W-1:0]    clock_q;
	logic [ID_W-1:0]      next_id_q;

	// Result register.
	logic              out_valid_q;
	status_t           out_status_q;
	logic [ID_W-1:0]   out_id_q;
	logic              out_fired_q;
	logic [TIME_W-1:0] out_time_q;
	logic              out_last_q;

	logic              accept;
	logic              quick;
	logic              live;
	logic              pool_hit;
	logic              due;
	logic              emit_hit;
	logic              last_idx;
	logic              destroy_en;
	logic              add_ok;
	logic              out_free;
	logic              out_load;
	logic [IW-1:0]     rd_addr;
	logic [LW-1:0]     limit;
	logic [CFG_W-1:0]  raw_limit;
	status_t           fin_status;
	logic [ID_W-1:0]   id_inc;

	// Request handshake and the early refusal of a zero delay.
	assign req.ready = cmd.ready;
	assign accept    = req.valid & cmd.ready;
	assign quick     = (req.op == OP_ADD) && (req.arm_delay == '0) && !req.late_ok;

	// Per-slot evaluation of the entry under the scan index.
	assign live       = active_q[idx_q];
	assign pool_hit   = (rd_s1.owner == pool_q);
	assign due        = (rd_s1.fire <= clock_q);
	assign emit_hit   = (op_q == OP_ADVANCE) && live && due;
	assign last_idx   = (idx_q == LAST_IDX);
	assign destroy_en = (pool_q != '0) && (NPW'(pool_q) < NP);

	// Alarm limit of the addressed pool.
	assign raw_limit = limit_cfg[pool_q];
	always_comb begin
		if (NPW'(pool_q) >= NP) begin
			limit = '0;
		end else if (pool_q == '0) begin
			limit = (raw_limit == '0) ? LW'(NUM_SLOTS) : LW'(raw_limit);
		end else if (raw_limit == '0) begin
			limit = LW'(1);
		end else if (LW'(raw_limit) > LW'(NUM_SLOTS)) begin
			limit = LW'(NUM_SLOTS);
		end else begin
			limit = LW'(raw_limit);
		end
	end

	assign add_ok = (op_q == OP_ADD) && !reject_q && (LW'(count_q) < limit) && free_found_q;

	// Status of the closing result.
	always_comb begin
		case (op_q)
			OP_ADD: begin
				if (reject_q) begin
					fin_status = ST_TIME_PASSED;
				end else if (LW'(count_q) >= limit) begin
					fin_status = ST_POOL_FULL;
				end else if (!free_found_q) begin
					fin_status = ST_NO_SLOT;
				end else begin
					fin_status = ST_OK;
				end
			end
			OP_CANCEL: fin_status = found_q ? ST_OK : ST_NOT_FOUND;
			default:   fin_status = ST_OK;
		endcase
	end

	assign id_inc   = next_id_q + ID_W'(1);
	assign out_free = !out_valid_q || rsp.ready;
	assign out_load = (cmd.step && emit_hit) || cmd.finish;
	assign rd_addr  = (cmd.step && !last_idx) ? idx_q + IW'(1) : idx_q;

	// Slot table: written by a successful add, read one slot per cycle.
	always_ff @(posedge clk) begin
		if (cmd.finish && add_ok) begin
			mem[free_idx_q] <= '{owner: pool_q, id: next_id_q,
				fire: clock_q + TIME_W'(delay_q)};
		end
		rd_s1 <= mem[rd_addr];
	end

	// Request fields held for the whole operation.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q     <= req.op;
			pool_q   <= req.pool_index;
			delay_q  <= req.arm_delay;
			target_q <= req.target_id;
			reject_q <= quick;
		end
	end

	// Scan bookkeeping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q        <= '0;
			count_q      <= '0;
			free_found_q <= 1'b0;
			found_q      <= 1'b0;
		end else if (accept) begin
			idx_q        <= '0;
			count_q      <= '0;
			free_found_q <= 1'b0;
			found_q      <= 1'b0;
		end else if (cmd.step) begin
			idx_q <= rd_addr;
			if (op_q == OP_ADD && live && pool_hit) begin
				count_q <= count_q + CW'(1);
			end
			if (op_q == OP_ADD && !live && !free_found_q) begin
				free_found_q <= 1'b1;
			end
			if (op_q == OP_CANCEL && !found_q && live && pool_hit && rd_s1.id == target_q) begin
				found_q <= 1'b1;
			end
		end
	end

	// Index of the lowest free slot.
	always_ff @(posedge clk) begin
		if (cmd.step && op_q == OP_ADD && !live && !free_found_q) begin
			free_idx_q <= idx_q;
		end
	end

	// Active flags, clock and id counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q  <= '0;
			clock_q   <= '0;
			next_id_q <= ID_W'(1);
		end else begin
			if (accept && req.op == OP_ADVANCE) begin
				clock_q <= clock_q + req.advance_us;
			end
			if (cmd.finish && add_ok) begin
				active_q[free_idx_q] <= 1'b1;
				next_id_q <= (id_inc == '0) ? ID_W'(1) : id_inc;
			end
			if (cmd.step) begin
				case (op_q)
					OP_CANCEL: begin
						if (!found_q && live && pool_hit && rd_s1.id == target_q) begin
							active_q[idx_q] <= 1'b0;
						end
					end
					OP_DESTROY: begin
						if (destroy_en && live && pool_hit) begin
							active_q[idx_q] <= 1'b0;
						end
					end
					OP_ADVANCE: begin
						if (live && due) begin
							active_q[idx_q] <= 1'b0;
						end
					end
					default: ;
				endcase
			end
		end
	end

	// Result register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result register payload: a fired alarm or the closing result.
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_time_q <= clock_q;
			if (cmd.finish) begin
				out_status_q <= fin_status;
				out_id_q     <= add_ok ? next_id_q : '0;
				out_fired_q  <= 1'b0;
				out_last_q   <= 1'b1;
			end else begin
				out_status_q <= ST_OK;
				out_id_q     <= rd_s1.id;
				out_fired_q  <= 1'b1;
				out_last_q   <= 1'b0;
			end
		end
	end

	assign rsp.valid    = out_valid_q;
	assign rsp.status   = out_status_q;
	assign rsp.timer_id = out_id_q;
	assign rsp.fired    = out_fired_q;
	assign rsp.time_now = out_time_q;
	assign rsp.last     = out_last_q;

	assign sts.accepted = accept;
	assign sts.quick    = quick;
	assign sts.emit_hit = emit_hit;
	assign sts.out_free = out_free;
	assign sts.last_idx = last_idx;

	// A result is never written over one that has not been taken.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!out_valid_q || rsp.ready))
		else $error("result register overwritten before transfer");

	// The id counter never hands out zero.
	a_id_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		next_id_q != '0)
		else $error("alarm id counter reached zero");

	// A reported alarm is freed.
	a_fired_freed: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.step && emit_hit) |=> !active_q[$past(idx_q)])
		else $error("fired alarm still active");

	// A successful add arms its slot.
	a_add_armed: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.finish && add_ok) |=> active_q[$past(free_idx_q)])
		else $error("added alarm slot not armed");

endmodule

`default_nettype wire

// File: src/asp_ctrl.sv
// Controller state machine of the alarm slot pool: accept, scan and close one request.
`default_nettype none

module asp_ctrl import asp_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  dp_sts_t sts,
	output dp_cmd_t cmd
);

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_PRIME  = 4'b0010,
		S_SCAN   = 4'b0100,
		S_FINISH = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_nxt;

	// Next state and datapath commands.
	always_comb begin
		state_nxt  = state_q;
		cmd.ready  = 1'b0;
		cmd.step   = 1'b0;
		cmd.finish = 1'b0;
		case (state_q)
			S_IDLE: begin
				cmd.ready = 1'b1;
				if (sts.accepted) begin
					state_nxt = sts.quick ? S_FINISH : S_PRIME;
				end
			end
			S_PRIME: begin
				state_nxt = S_SCAN;
			end
			S_SCAN: begin
				// A due alarm waits for room in the result register.
				cmd.step = !(sts.emit_hit && !sts.out_free);
				if (cmd.step && sts.last_idx) begin
					state_nxt = S_FINISH;
				end
			end
			S_FINISH: begin
				cmd.finish = sts.out_free;
				if (sts.out_free) begin
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

`default_nettype wire
